@@ rtl/led_fade_and_auto_off_controller_core_macros.svh @@
// ----------------------------------------------------------------------------
// LED fade and auto-off controller - assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef LED_FADE_AND_AUTO_OFF_CONTROLLER_CORE_MACROS_SVH
`define LED_FADE_AND_AUTO_OFF_CONTROLLER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, quiet during reset
`define LFAC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
// next-cycle implication, sampled on clk, quiet during reset
`define LFAC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define LFAC_ASSERT_IMP(lbl, ante, cons, msg)
`define LFAC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/lfac_pkg.sv @@
// ----------------------------------------------------------------------------
// LED fade and auto-off controller - package
// Command codes, register indexes, item types and the level update functions.
// ----------------------------------------------------------------------------
package lfac_pkg;

	localparam logic [2:0] REQ_TICK      = 3'd0;
	localparam logic [2:0] REQ_ON        = 3'd1;
	localparam logic [2:0] REQ_OFF       = 3'd2;
	localparam logic [2:0] REQ_FADE      = 3'd3;
	localparam logic [2:0] REQ_TIMER     = 3'd4;
	localparam logic [2:0] REQ_MIN       = 3'd5;
	localparam logic [2:0] REQ_STEP_UP   = 3'd6;
	localparam logic [2:0] REQ_STEP_DOWN = 3'd7;

	localparam logic KIND_RELAY = 1'b0;
	localparam logic KIND_PWM   = 1'b1;

	localparam logic [1:0] CFG_IDX_KIND = 2'd0;
	localparam logic [1:0] CFG_IDX_MIN  = 2'd1;
	localparam logic [1:0] CFG_IDX_MAX  = 2'd2;

	localparam logic       CFG_KIND_RST = KIND_PWM;
	localparam logic [7:0] CFG_MIN_RST  = 8'd0;
	localparam logic [7:0] CFG_MAX_RST  = 8'd255;

	// result queue: three entries cover the input stage plus a stalled receiver
	localparam int unsigned OUTQ_DEPTH = 3;

	typedef struct packed {
		logic       kind;
		logic [7:0] lmin;
		logic [7:0] lmax;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic        fade_upward;
		logic [7:0]  step_size;
		logic [15:0] fade_period;
		logic [31:0] on_duration;
	} item_t;

	typedef struct packed {
		logic [7:0]  level;
		logic        fade_on;
		logic        fade_dir;
		logic [7:0]  fade_step;
		logic [15:0] fade_gap;
		logic [31:0] last_fade;
		logic [31:0] timer_start;
		logic [31:0] timer_len;
	} st_t;

	typedef struct packed {
		logic       acted;
		logic       fading;
		logic       is_lit;
		logic [7:0] drive_level;
	} res_t;

	function automatic logic lit(st_t s, cfg_t c);
		return (c.kind == KIND_RELAY) ? (s.level == c.lmax) : (s.level != 8'd0);
	endfunction

	function automatic st_t clear_fade(st_t s);
		st_t r;
		r           = s;
		r.fade_on   = 1'b0;
		r.fade_dir  = 1'b0;
		r.fade_step = 8'd0;
		r.fade_gap  = 16'd0;
		r.last_fade = 32'd0;
		return r;
	endfunction

	function automatic st_t switch_on(st_t s, cfg_t c);
		st_t r;
		r       = clear_fade(s);
		r.level = c.lmax;
		return r;
	endfunction

	// relay keeps the ramp, PWM drops it; the timer is disarmed either way
	function automatic st_t switch_off(st_t s, cfg_t c);
		st_t r;
		r = s;
		if (c.kind == KIND_RELAY) begin
			r.level = c.lmin;
		end else begin
			r       = clear_fade(s);
			r.level = 8'd0;
		end
		r.timer_len = 32'd0;
		return r;
	endfunction

	// saturate at maximum; from dark, jump to the minimum instead of adding
	function automatic st_t step_up(st_t s, logic [7:0] sz, cfg_t c);
		st_t        r;
		logic [8:0] sum;
		r   = s;
		sum = {1'b0, s.level} + {1'b0, sz};
		if (sum >= {1'b0, c.lmax}) begin
			r       = clear_fade(s);
			r.level = c.lmax;
		end else if (lit(s, c)) begin
			r.level = sum[7:0];
		end else begin
			r.level = c.lmin;
		end
		return r;
	endfunction

	function automatic st_t step_down(st_t s, logic [7:0] sz);
		st_t r;
		r = s;
		if (s.level <= sz) begin
			r       = clear_fade(s);
			r.level = 8'd0;
		end else begin
			r.level = s.level - sz;
		end
		return r;
	endfunction

endpackage

@@ rtl/lfac_state.sv @@
// ----------------------------------------------------------------------------
// LED fade and auto-off controller - command stage
// Holds the light state and clock, applies one registered command per cycle while in_valid is high.
// ----------------------------------------------------------------------------
module lfac_state import lfac_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  item_t item,
	input  cfg_t  cfg,
	output logic  res_valid,
	output res_t  res
);

	st_t         st_q;
	st_t         st_nx;
	logic [31:0] now_q;
	logic [31:0] now_nx;
	logic        run_chk;
	logic        fade_due;
	logic        timer_due;
	logic [31:0] fade_elapsed;
	logic [31:0] timer_elapsed;

	always_comb begin
		st_nx   = st_q;
		now_nx  = now_q;
		run_chk = 1'b0;
		unique case (item.req_type)
			REQ_TICK: begin
				now_nx  = now_q + 32'd1;
				run_chk = 1'b1;
			end
			REQ_ON: begin
				st_nx = switch_on(st_q, cfg);
			end
			REQ_OFF: begin
				st_nx = switch_off(st_q, cfg);
			end
			REQ_FADE: begin
				st_nx.fade_on   = 1'b1;
				st_nx.fade_dir  = item.fade_upward;
				st_nx.fade_step = item.step_size;
				st_nx.fade_gap  = item.fade_period;
				run_chk         = 1'b1;
			end
			REQ_TIMER: begin
				st_nx.timer_start = now_q;
				st_nx.timer_len   = item.on_duration;
				if (!lit(st_q, cfg)) begin
					st_nx = switch_on(st_nx, cfg);
				end
			end
			REQ_MIN: begin
				st_nx.level = cfg.lmin;
			end
			REQ_STEP_UP: begin
				st_nx = step_up(st_q, item.step_size, cfg);
			end
			REQ_STEP_DOWN: begin
				st_nx = step_down(st_q, item.step_size);
			end
		endcase

		// fade check, then timer check on what the fade left
		fade_elapsed = now_nx - st_nx.last_fade;
		fade_due     = run_chk && st_nx.fade_on && (fade_elapsed > {16'd0, st_nx.fade_gap});
		if (fade_due) begin
			if (st_nx.fade_dir) begin
				st_nx = step_up(st_nx, st_nx.fade_step, cfg);
			end else begin
				st_nx = step_down(st_nx, st_nx.fade_step);
			end
			st_nx.last_fade = now_nx;
		end
		timer_elapsed = now_nx - st_nx.timer_start;
		timer_due     = run_chk && (st_nx.timer_len != 32'd0)
			&& (timer_elapsed > st_nx.timer_len);
		if (timer_due) begin
			st_nx = switch_off(st_nx, cfg);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			now_q <= 32'd0;
		end else if (in_valid) begin
			st_q  <= st_nx;
			now_q <= now_nx;
		end
	end

	assign res_valid       = in_valid;
	assign res.drive_level = st_nx.level;
	assign res.is_lit      = lit(st_nx, cfg);
	assign res.fading      = st_nx.fade_on;
	assign res.acted       = fade_due || timer_due;

endmodule

@@ rtl/lfac_outq.sv @@
// ----------------------------------------------------------------------------
// LED fade and auto-off controller - result queue
// Small circular buffer of result items in front of the output channel.
// ----------------------------------------------------------------------------
module lfac_outq import lfac_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  res_t       push_data,
	input  logic       pop_ready,
	output logic       out_valid,
	output res_t       out_data,
	output logic [1:0] cnt
);

	localparam logic [1:0] LAST_IDX = 2'(OUTQ_DEPTH - 1);

	res_t       mem_q [OUTQ_DEPTH];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && pop_ready;
	assign cnt       = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? 2'd0 : wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? 2'd0 : rd_ptr_q + 2'd1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

@@ rtl/led_fade_and_auto_off_controller_core.sv @@
// ----------------------------------------------------------------------------
// LED fade and auto-off controller - top level
// Light level, fade ramp and auto-off timer for one relay or PWM output.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one command item per handshake (kind in s_tuser, the
//   operands in s_tdata); every command yields exactly one result item on m_*.
//   cfg_* writes output kind, minimum and maximum level; write only when idle.
// Path: a taken command is held in the input register; the command logic
//   then applies it and pushes its result into the queue at the same edge,
//   and the result is on m_tvalid from that edge on.
// Throughput: one item per cycle while s_tready stays high, set by the single
//   command stage that reads and writes the light state in the same cycle.
// Stall: results collect in a three-entry queue; s_tready drops when the
//   queue and the input register together hold three items. In a steady
//   stream that happens the cycle after m_tready first goes low, so even a
//   one-cycle stall holds the input back.
// Reset: arst_n clears the clock, the fade, the timer and the queue; the
//   registers return to PWM kind, minimum 0, maximum 255, so the level is 0.
// ----------------------------------------------------------------------------
`include "led_fade_and_auto_off_controller_core_macros.svh"

module led_fade_and_auto_off_controller_core import lfac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// command items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // fade_upward[0], step_size[8:1],
	                               // fade_period[24:9], on_duration[56:25], zero fill
	input  logic [2:0]  s_tuser,   // req_type[2:0]
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // drive_level[7:0], is_lit[8], fading[9],
	                               // acted[10], zero fill
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	cfg_t       cfg_q;
	item_t      item_s1;
	logic       valid_s1;
	logic       s_accept;
	logic       res_valid;
	res_t       res;
	res_t       q_data;
	logic [1:0] q_cnt;
	logic [2:0] occ;
	logic       q_full;
	logic       no_chk;
	logic       pwm_off;
	logic       res_dark;

	// registers: always ready, unknown index ignored
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kind <= CFG_KIND_RST;
			cfg_q.lmin <= CFG_MIN_RST;
			cfg_q.lmax <= CFG_MAX_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_IDX_KIND: cfg_q.kind <= cfg_data[0];
				CFG_IDX_MIN:  cfg_q.lmin <= cfg_data;
				CFG_IDX_MAX:  cfg_q.lmax <= cfg_data;
				default: ;
			endcase
		end
	end

	// admit a command only if its result is sure to find a queue slot
	assign occ      = {1'b0, q_cnt} + {2'b00, valid_s1};
	assign s_tready = (occ < 3'(OUTQ_DEPTH));
	assign s_accept = s_tvalid && s_tready;

	// input register: the command stage drains it every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1.req_type    <= s_tuser;
			item_s1.fade_upward <= s_tdata[0];
			item_s1.step_size   <= s_tdata[8:1];
			item_s1.fade_period <= s_tdata[24:9];
			item_s1.on_duration <= s_tdata[56:25];
		end
	end

	lfac_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.item      (item_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	lfac_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (q_data),
		.cnt       (q_cnt)
	);

	assign m_tdata = {5'd0, q_data.acted, q_data.fading, q_data.is_lit, q_data.drive_level};

	// terms for the checks below
	assign q_full   = (q_cnt == 2'(OUTQ_DEPTH));
	assign no_chk   = (item_s1.req_type != REQ_TICK) && (item_s1.req_type != REQ_FADE);
	assign pwm_off  = (item_s1.req_type == REQ_OFF) && (cfg_q.kind == KIND_PWM);
	assign res_dark = (res.drive_level == 8'd0) && !res.fading && !res.is_lit;

	// admission must never let queue plus input register exceed the queue depth
	`LFAC_ASSERT_IMP(a_occ_bound, 1'b1, occ <= 3'(OUTQ_DEPTH), "result queue overbooked")
	// a result is never pushed into a full queue that is not draining
	`LFAC_ASSERT_IMP(a_push_room, res_valid, !q_full || m_tready, "push into full queue")
	// only tick and start fade run the checks that can report an action
	`LFAC_ASSERT_IMP(a_acted_src, res_valid && no_chk, !res.acted, "acted without checks")
	// a PWM off leaves the output dark with no ramp
	`LFAC_ASSERT_IMP(a_pwm_off, res_valid && pwm_off, res_dark, "PWM off left light or fade")

endmodule

@@ dv/light_result_checker.sv @@
// ----------------------------------------------------------------------------
// Light controller result checker
// Watches the command, result and register channels of the light controller,
// keeps its own copy of the light state and compares every result item.
// ----------------------------------------------------------------------------
module light_result_checker import lfac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,   // fade_upward[0], step_size[8:1],
	                               // fade_period[24:9], on_duration[56:25], zero fill
	input  logic [2:0]  s_tuser,   // req_type[2:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // drive_level[7:0], is_lit[8], fading[9],
	                               // acted[10], zero fill
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          fail_count,
	output int          outstanding
);

	logic        cfg_kind;
	logic [7:0]  cfg_lmin;
	logic [7:0]  cfg_lmax;

	logic [31:0] clock_ms;
	logic [7:0]  level;
	logic        ramp_on;
	logic        ramp_up;
	logic [7:0]  ramp_step;
	logic [15:0] ramp_gap;
	logic [31:0] ramp_mark;
	logic [31:0] timer_mark;
	logic [31:0] timer_len;

	res_t        expected_light_q[$];
	int          mismatches;
	int          results_seen;

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("mismatch on result %0d: %s", results_seen, what);
	endtask

	task automatic compare_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	function automatic logic shows_lit();
		return (cfg_kind == KIND_RELAY) ? (level == cfg_lmax) : (level != 8'd0);
	endfunction

	task automatic drop_ramp();
		ramp_on   = 1'b0;
		ramp_up   = 1'b0;
		ramp_step = 8'd0;
		ramp_gap  = 16'd0;
		ramp_mark = 32'd0;
	endtask

	task automatic go_full();
		level = cfg_lmax;
		drop_ramp();
	endtask

	task automatic go_dark();
		if (cfg_kind == KIND_RELAY) begin
			level = cfg_lmin;
		end else begin
			level = 8'd0;
			drop_ramp();
		end
		timer_len = 32'd0;
	endtask

	task automatic nudge_up(input logic [7:0] sz);
		logic [8:0] sum;
		sum = {1'b0, level} + {1'b0, sz};
		if (sum >= {1'b0, cfg_lmax}) begin
			level = cfg_lmax;
			drop_ramp();
		end else if (!shows_lit()) begin
			level = cfg_lmin;
		end else begin
			level = sum[7:0];
		end
	endtask

	task automatic nudge_down(input logic [7:0] sz);
		if (level <= sz) begin
			level = 8'd0;
			drop_ramp();
		end else begin
			level = level - sz;
		end
	endtask

	// fade step first, then auto-off; elapsed times wrap at 32 bits
	task automatic run_checks(output logic fired);
		logic [31:0] since;
		fired = 1'b0;
		since = clock_ms - ramp_mark;
		if (ramp_on && since > {16'd0, ramp_gap}) begin
			if (ramp_up)
				nudge_up(ramp_step);
			else
				nudge_down(ramp_step);
			ramp_mark = clock_ms;
			fired     = 1'b1;
		end
		since = clock_ms - timer_mark;
		if (timer_len != 32'd0 && since > timer_len) begin
			go_dark();
			fired = 1'b1;
		end
	endtask

	task automatic apply_light_command(input item_t cmd, output res_t r);
		logic fired;
		fired = 1'b0;
		case (cmd.req_type)
			REQ_TICK: begin
				clock_ms = clock_ms + 32'd1;
				run_checks(fired);
			end
			REQ_ON: go_full();
			REQ_OFF: go_dark();
			REQ_FADE: begin
				ramp_on   = 1'b1;
				ramp_up   = cmd.fade_upward;
				ramp_step = cmd.step_size;
				ramp_gap  = cmd.fade_period;
				run_checks(fired);
			end
			REQ_TIMER: begin
				timer_mark = clock_ms;
				timer_len  = cmd.on_duration;
				if (!shows_lit())
					go_full();
			end
			REQ_MIN: level = cfg_lmin;
			REQ_STEP_UP: nudge_up(cmd.step_size);
			default: nudge_down(cmd.step_size);
		endcase
		r.drive_level = level;
		r.is_lit      = shows_lit();
		r.fading      = ramp_on;
		r.acted       = fired;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		item_t cmd;
		res_t  want;
		res_t  got;
		if (!arst_n) begin
			cfg_kind     = CFG_KIND_RST;
			cfg_lmin     = CFG_MIN_RST;
			cfg_lmax     = CFG_MAX_RST;
			clock_ms     = 32'd0;
			timer_mark   = 32'd0;
			timer_len    = 32'd0;
			drop_ramp();
			level        = (cfg_kind == KIND_RELAY) ? cfg_lmin : 8'd0;
			expected_light_q.delete();
			mismatches   = 0;
			results_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				// out-of-range index is dropped
				case (cfg_index)
					CFG_IDX_KIND: cfg_kind = cfg_data[0];
					CFG_IDX_MIN:  cfg_lmin = cfg_data;
					CFG_IDX_MAX:  cfg_lmax = cfg_data;
					default: ;
				endcase
			end
			// results go first: an item taken at this edge cannot be out yet
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata[10:0]);
				results_seen++;
				if (expected_light_q.size() == 0) begin
					report_mismatch("result item with nothing expected");
				end else begin
					want = expected_light_q.pop_front();
					compare_field("drive_level", got.drive_level, want.drive_level);
					compare_field("is_lit", got.is_lit, want.is_lit);
					compare_field("fading", got.fading, want.fading);
					compare_field("acted", got.acted, want.acted);
				end
			end
			if (s_tvalid && s_tready) begin
				cmd.req_type    = s_tuser;
				cmd.fade_upward = s_tdata[0];
				cmd.step_size   = s_tdata[8:1];
				cmd.fade_period = s_tdata[24:9];
				cmd.on_duration = s_tdata[56:25];
				apply_light_command(cmd, want);
				expected_light_q.push_back(want);
			end
		end
		fail_count  <= mismatches;
		outstanding <= expected_light_q.size();
	end

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Light controller testbench top
// Drives command items and register writes into the light controller, stalls
// the result side on a pattern of its own, and gives the verdict from the
// checker's mismatch count. Directed corner items come first, then random
// scenes (fade ramps, auto-off timers, loose commands) under several register
// settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;
	import lfac_pkg::*;

	// register index the block has no register for
	localparam logic [1:0] CFG_IDX_SPARE = 2'd3;
	// cycles with no handshake on any channel before giving up
	localparam int QUIET_LIMIT = 4000;
	// random items per register setting
	localparam int PHASE_ITEMS = 116;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // fade_upward[0], step_size[8:1],
	                        // fade_period[24:9], on_duration[56:25], zero fill
	logic [2:0]  s_tuser;   // req_type[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // drive_level[7:0], is_lit[8], fading[9],
	                        // acted[10], zero fill
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	int fail_count;
	int outstanding;
	int items_sent;
	int burst_left;
	int quiet_cycles;
	int sink_cycle;
	int sink_hold;

	led_fade_and_auto_off_controller_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	light_result_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Result side: cycle through always ready, random stalls and stall runs,
	// switching pattern as sink_cycle runs on so stalls land on every phase.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			sink_cycle++;
			case ((sink_cycle / 97) % 3)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: begin
					if (sink_hold > 0) begin
						sink_hold--;
						m_tready <= 1'b0;
					end else if ($urandom_range(0, 5) == 0) begin
						sink_hold = $urandom_range(1, 10);
						m_tready  <= 1'b0;
					end else begin
						m_tready <= 1'b1;
					end
				end
			endcase
		end
	end

	// Watchdog: end the run when no channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
		             || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic item_t make_cmd(input logic [2:0] req, input logic up,
	                                   input logic [7:0] sz, input logic [15:0] per,
	                                   input logic [31:0] dur);
		item_t c;
		c.req_type    = req;
		c.fade_upward = up;
		c.step_size   = sz;
		c.fade_period = per;
		c.on_duration = dur;
		return c;
	endfunction

	// Offer one item and hold it until taken; at the end of a burst may drop valid
	// for a random gap.
	task automatic send_cmd(input item_t c);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, c.on_duration, c.fade_period, c.step_size, c.fade_upward};
		s_tuser  <= c.req_type;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_tick();
		send_cmd(make_cmd(REQ_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
		                  16'($urandom_range(0, 65535)), $urandom()));
	endtask

	// Drop valid, wait for every expected result, then let the pipe drain.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_setting(input logic kind, input logic [7:0] lmin,
	                             input logic [7:0] lmax, input logic poke_spare);
		settle();
		if (poke_spare)
			write_reg(CFG_IDX_SPARE, 8'hFF);
		write_reg(CFG_IDX_KIND, {7'd0, kind});
		write_reg(CFG_IDX_MIN, lmin);
		write_reg(CFG_IDX_MAX, lmax);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_step();
		return 8'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 40)
		                                      : $urandom_range(0, 255));
	endfunction

	function automatic logic [15:0] pick_period();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 7)
			return 16'($urandom_range(0, 4));
		if (roll < 9)
			return 16'($urandom_range(0, 30));
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic logic [31:0] pick_duration();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll < 3)
			return 32'd0;
		if (roll < 14)
			return $urandom_range(1, 30);
		return $urandom();
	endfunction

	// Loose command: ticks dominate, every other kind shows up regularly.
	function automatic item_t random_cmd();
		int         roll;
		logic [2:0] req;
		roll = $urandom_range(0, 99);
		if (roll < 42)      req = REQ_TICK;
		else if (roll < 54) req = REQ_FADE;
		else if (roll < 62) req = REQ_TIMER;
		else if (roll < 68) req = REQ_ON;
		else if (roll < 74) req = REQ_OFF;
		else if (roll < 80) req = REQ_MIN;
		else if (roll < 90) req = REQ_STEP_UP;
		else                req = REQ_STEP_DOWN;
		return make_cmd(req, 1'($urandom_range(0, 1)), pick_step(), pick_period(),
		                pick_duration());
	endfunction

	// Ramp or timer followed by a run of ticks, or a single loose command.
	task automatic random_scene();
		int roll;
		int n;
		roll = $urandom_range(0, 9);
		if (roll < 3) begin
			send_cmd(make_cmd(REQ_FADE, 1'($urandom_range(0, 1)), pick_step(),
			                  16'($urandom_range(0, 5)), $urandom()));
			n = $urandom_range(3, 25);
			repeat (n) begin
				if ($urandom_range(0, 9) == 0)
					send_cmd(random_cmd());
				else
					send_tick();
			end
		end else if (roll < 5) begin
			n = $urandom_range(1, 15);
			send_cmd(make_cmd(REQ_TIMER, 1'($urandom_range(0, 1)), pick_step(),
			                  pick_period(), 32'(n)));
			repeat (n + $urandom_range(0, 4)) send_tick();
		end else begin
			send_cmd(random_cmd());
		end
	endtask

	task automatic random_phase();
		int goal;
		goal = items_sent + PHASE_ITEMS;
		while (items_sent < goal)
			random_scene();
	endtask

	initial begin
		arst_n       <= 1'b0;
		s_tvalid     <= 1'b0;
		s_tdata      <= 64'd0;
		s_tuser      <= REQ_TICK;
		cfg_valid    <= 1'b0;
		cfg_index    <= CFG_IDX_KIND;
		cfg_data     <= 8'd0;
		items_sent   = 0;
		burst_left   = 1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners under the reset setting (PWM, 0..255).
		send_cmd(make_cmd(REQ_TICK, 1'b0, 8'd0, 16'd0, 32'd0));
		send_cmd(make_cmd(REQ_ON, 1'b1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF));
		send_cmd(make_cmd(REQ_OFF, 1'b0, 8'd0, 16'd0, 32'd0));
		// step up from dark jumps to the minimum
		send_cmd(make_cmd(REQ_STEP_UP, 1'b0, 8'd0, 16'd0, 32'd0));
		send_cmd(make_cmd(REQ_STEP_UP, 1'b0, 8'd255, 16'd0, 32'd0));
		send_cmd(make_cmd(REQ_STEP_DOWN, 1'b0, 8'd0, 16'd0, 32'd0));
		send_cmd(make_cmd(REQ_STEP_DOWN, 1'b0, 8'd255, 16'd0, 32'd0));
		send_cmd(make_cmd(REQ_MIN, 1'b0, 8'd0, 16'd0, 32'd0));
		send_cmd(make_cmd(REQ_ON, 1'b0, 8'd0, 16'd0, 32'd0));
		send_cmd(make_cmd(REQ_STEP_DOWN, 1'b0, 8'd100, 16'd0, 32'd0));
		send_cmd(make_cmd(REQ_STEP_UP, 1'b0, 8'd50, 16'd0, 32'd0));
		// zero fade period steps at once, without advancing the clock
		send_cmd(make_cmd(REQ_FADE, 1'b0, 8'd30, 16'd0, 32'd0));
		send_cmd(make_cmd(REQ_TICK, 1'b0, 8'd0, 16'd0, 32'd0));
		send_cmd(make_cmd(REQ_TICK, 1'b0, 8'd0, 16'd0, 32'd0));
		send_cmd(make_cmd(REQ_FADE, 1'b1, 8'd255, 16'hFFFF, 32'hFFFF_FFFF));
		send_cmd(make_cmd(REQ_TICK, 1'b1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF));
		// zero duration disables, all-ones never expires here, short one does
		send_cmd(make_cmd(REQ_TIMER, 1'b0, 8'd0, 16'd0, 32'd0));
		send_cmd(make_cmd(REQ_TIMER, 1'b1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF));
		send_cmd(make_cmd(REQ_OFF, 1'b0, 8'd0, 16'd0, 32'd0));
		send_cmd(make_cmd(REQ_TIMER, 1'b0, 8'd0, 16'd0, 32'd2));
		repeat (4) send_cmd(make_cmd(REQ_TICK, 1'b0, 8'd0, 16'd0, 32'd0));
		send_cmd(make_cmd(REQ_STEP_DOWN, 1'b1, 8'd1, 16'd0, 32'd0));
		random_phase();

		// Relay full range, then dimmer and relay windows, inverted windows with the
		// minimum above the maximum, an equal pair, and PWM 0..255 after a spare write.
		apply_setting(KIND_RELAY, 8'd0, 8'd255, 1'b0);
		random_phase();
		apply_setting(KIND_PWM, 8'd20, 8'd200, 1'b0);
		random_phase();
		apply_setting(KIND_RELAY, 8'd60, 8'd180, 1'b0);
		random_phase();
		apply_setting(KIND_RELAY, 8'd200, 8'd50, 1'b0);
		random_phase();
		apply_setting(KIND_PWM, 8'd255, 8'd0, 1'b0);
		random_phase();
		apply_setting(KIND_RELAY, 8'd255, 8'd255, 1'b0);
		random_phase();
		apply_setting(KIND_PWM, 8'd0, 8'd255, 1'b1);
		random_phase();

		settle();
		if (fail_count == 0 && outstanding == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
